@@ rtl/hex_argument_list_parser_assert.svh @@
// ----------------------------------------------------------------------------
// Hex argument list parser: assertion macros
// Clocked checks shared by the parser and the result queue.
// ----------------------------------------------------------------------------
`ifndef HEX_ARGUMENT_LIST_PARSER_ASSERT_SVH
`define HEX_ARGUMENT_LIST_PARSER_ASSERT_SVH

// check held outside reset
`define HAP_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check held on every edge, reset included
`define HAP_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/hap_pkg.sv @@
// ----------------------------------------------------------------------------
// Hex argument list parser package
// Result record type, record kinds, character codes and the hex decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hap_pkg;

  localparam int DEF_PARAM_SLOTS = 8;
  localparam int DEF_VALUE_BITS  = 32;
  localparam int FIFO_DEPTH      = 4;

  localparam logic [1:0] KIND_VALUE    = 2'd0;
  localparam logic [1:0] KIND_DONE     = 2'd1;
  localparam logic [1:0] KIND_NO_PAREN = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot_index;
    logic [31:0] param_value;
    logic [3:0]  field_count;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    rec0;
    result_t    rec1;
  } push_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

@@ rtl/hap_parser.sv @@
// ----------------------------------------------------------------------------
// Hex argument list parser: character parser
// Per-word state update of the command parser and its zero to two records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hex_argument_list_parser_assert.svh"

module hap_parser #(
  parameter int PARAM_SLOTS = hap_pkg::DEF_PARAM_SLOTS,
  parameter int VALUE_BITS  = hap_pkg::DEF_VALUE_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      char_byte,
  output hap_pkg::push_t  push
);

  localparam int CW = $clog2(PARAM_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_MAX = CW'(PARAM_SLOTS);

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_SEEK  = 3'd1;
  localparam logic [2:0] PH_LIST  = 3'd2;
  localparam logic [2:0] PH_AFTER = 3'd3;
  localparam logic [2:0] PH_EQUAL = 3'd4;
  localparam logic [2:0] PH_IDLE  = 3'd5;

  logic [2:0]            phase, phase_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic                  seen, seen_next;
  logic [CW-1:0]         slot_count, slot_count_next;

  logic                  field_ok, do_close, emit_field, emit_end;
  logic [1:0]            end_kind;
  logic [CW-1:0]         slot_closed, end_count;
  logic [4:0]            hv;
  logic [63:0]           acc_wide, slot_wide, count_wide;
  hap_pkg::result_t      field_rec, end_rec;

  assign hv          = hap_pkg::hex_nibble(char_byte);
  assign field_ok    = seen && (slot_count < SLOTS_MAX);
  assign slot_closed = slot_count + CW'(field_ok);

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    seen_next       = seen;
    slot_count_next = slot_count;
    do_close        = 1'b0;
    emit_end        = 1'b0;
    end_kind        = hap_pkg::KIND_DONE;
    end_count       = slot_count;
    unique case (phase)
      PH_FIRST, PH_SEEK: begin
        if (char_byte == hap_pkg::CH_NUL) begin
          emit_end = 1'b1;
          end_kind = hap_pkg::KIND_NO_PAREN;
          end_count = '0;
        end else if (phase == PH_FIRST) begin
          phase_next = PH_SEEK;
        end else if (char_byte == hap_pkg::CH_OPEN) begin
          phase_next      = PH_LIST;
          acc_next        = '0;
          seen_next       = 1'b0;
          slot_count_next = '0;
        end
      end
      PH_LIST, PH_EQUAL: begin
        if (char_byte == hap_pkg::CH_NUL) begin
          do_close  = 1'b1;
          emit_end  = 1'b1;
          end_count = slot_closed;
        end else if (char_byte == hap_pkg::CH_COMMA) begin
          do_close = 1'b1;
          if (phase == PH_EQUAL) begin
            phase_next = PH_IDLE;
          end else if (slot_closed >= SLOTS_MAX) begin
            phase_next = PH_AFTER;
          end
        end else if (char_byte == hap_pkg::CH_CLOSE) begin
          do_close   = 1'b1;
          phase_next = (phase == PH_EQUAL) ? PH_IDLE : PH_AFTER;
        end else if (char_byte == hap_pkg::CH_LF || char_byte == hap_pkg::CH_CR) begin
          do_close   = 1'b1;
          phase_next = PH_IDLE;
        end else if (char_byte != hap_pkg::CH_SPACE && hv[4]) begin
          acc_next  = VALUE_BITS'({acc, hv[3:0]});
          seen_next = 1'b1;
        end
        if (do_close) begin
          acc_next        = '0;
          seen_next       = 1'b0;
          slot_count_next = slot_closed;
        end
      end
      PH_AFTER: begin
        if (char_byte == hap_pkg::CH_NUL) begin
          emit_end = 1'b1;
        end else if (char_byte == hap_pkg::CH_EQUAL) begin
          acc_next   = '0;
          seen_next  = 1'b0;
          phase_next = PH_EQUAL;
        end else if (char_byte != hap_pkg::CH_SPACE && char_byte != hap_pkg::CH_CLOSE) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        if (char_byte == hap_pkg::CH_NUL) begin
          emit_end = 1'b1;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase
    if (emit_end) begin
      phase_next      = PH_FIRST;
      acc_next        = '0;
      seen_next       = 1'b0;
      slot_count_next = '0;
    end
  end

  assign emit_field = do_close && field_ok;
  assign acc_wide   = 64'(acc);
  assign slot_wide  = 64'(slot_count);
  assign count_wide = 64'(end_count);

  always_comb begin
    field_rec             = '0;
    field_rec.kind        = hap_pkg::KIND_VALUE;
    field_rec.slot_index  = slot_wide[2:0];
    field_rec.param_value = acc_wide[31:0];
    field_rec.last_of_run = !emit_end;
    end_rec               = '0;
    end_rec.kind          = end_kind;
    end_rec.field_count   = count_wide[3:0];
    end_rec.last_of_run   = 1'b1;
    push      = '0;
    push.rec0 = emit_field ? field_rec : end_rec;
    push.rec1 = end_rec;
    if (step) begin
      push.n = 2'(emit_field) + 2'(emit_end);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FIRST;
      acc        <= '0;
      seen       <= 1'b0;
      slot_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      acc        <= acc_next;
      seen       <= seen_next;
      slot_count <= slot_count_next;
    end
  end

  `HAP_CHECK(a_end_restarts, step && emit_end |=> phase == PH_FIRST && slot_count == '0 && !seen, "end record did not restart the command")
  `HAP_CHECK(a_slot_bound, slot_count <= SLOTS_MAX, "slot count beyond slot total")

endmodule

@@ rtl/hap_out_fifo.sv @@
// ----------------------------------------------------------------------------
// Hex argument list parser: result queue
// Small ring of result records, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hex_argument_list_parser_assert.svh"

module hap_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  hap_pkg::push_t    push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output hap_pkg::result_t  out_rec
);

  localparam int PW = $clog2(hap_pkg::FIFO_DEPTH);
  localparam int FW = $clog2(hap_pkg::FIFO_DEPTH + 1);

  hap_pkg::result_t mem [hap_pkg::FIFO_DEPTH];
  logic [PW-1:0]    wp, rp;
  logic [FW-1:0]    fill, fill_next;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = fill != '0;
  assign out_rec   = mem[rp];
  assign room      = fill <= FW'(hap_pkg::FIFO_DEPTH - 2);
  assign fill_next = fill + FW'(push.n) - FW'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wp] <= push.rec0;
    end
    if (push.n == 2'd2) begin
      mem[PW'(wp + PW'(1))] <= push.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      wp   <= wp + PW'(push.n);
      rp   <= rp + PW'(pop);
      fill <= fill_next;
    end
  end

  `HAP_CHECK_ALWAYS(a_fill_bound, rst || fill <= FW'(hap_pkg::FIFO_DEPTH), "queue fill beyond depth")
  `HAP_CHECK(a_no_overrun, push.n != 2'd0 |-> 32'(fill) + 32'(push.n) <= hap_pkg::FIFO_DEPTH, "queue written while full")

endmodule

@@ rtl/hex_argument_list_parser.sv @@
// ----------------------------------------------------------------------------
// Hex argument list parser
// Parses a command line such as CMD (a,b,c)=d one character per word and
// streams a record per hex field, then a done or no-parenthesis record.
//
//   channel  dir  tdata                       tuser      tlast
//   s_       in   [7:0] char_byte             -          -
//   m_       out  [2:0] slot_index,           [1:0] kind last_of_run
//                 [34:3] param_value,
//                 [38:35] field_count
//
// One character a cycle while s_tready is high; the parser state updates in
// the accepting cycle. A character causes up to two records; the queue drains
// one a cycle while m_tready is high, so two records take two transfers.
// s_tready drops only while the queue holds fewer than two free entries.
// Synchronous active-high reset returns to the first character of a command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_argument_list_parser #(
  parameter int PARAM_SLOTS = hap_pkg::DEF_PARAM_SLOTS,
  parameter int VALUE_BITS  = hap_pkg::DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [2:0] slot_index, [34:3] param_value, [38:35] field_count
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  hap_pkg::push_t   push;
  hap_pkg::result_t out_rec;
  logic             step;

  assign step = s_tvalid && s_tready;

  hap_parser #(
    .PARAM_SLOTS (PARAM_SLOTS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_byte (s_tdata),
    .push      (push)
  );

  hap_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec)
  );

  assign m_tdata = {1'b0, out_rec.field_count, out_rec.param_value, out_rec.slot_index};
  assign m_tuser = out_rec.kind;
  assign m_tlast = out_rec.last_of_run;

endmodule

@@ dv/hap_record_check.sv @@
// ----------------------------------------------------------------------------
// Hex argument list parser: record check
// Follows every character word taken on the input channel, predicts the
// value, done and no-parenthesis records it causes, and compares each record
// taken on the output channel with the oldest one still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hap_record_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [2:0] slot_index, [34:3] param_value, [38:35] field_count
  input  logic [1:0]  m_tuser,   // [1:0] kind
  input  logic        m_tlast,
  output int          errors,
  output int          pending,
  output int          records
);

  localparam int SLOTS = hap_pkg::DEF_PARAM_SLOTS;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SEEK,
    PH_LIST,
    PH_AFTER,
    PH_EQUAL,
    PH_IDLE
  } parse_phase_t;

  parse_phase_t      phase       = PH_FIRST;
  logic [31:0]       acc         = '0;
  logic              digits      = 1'b0;
  logic [3:0]        slot_count  = '0;

  hap_pkg::result_t  step_out[2];
  int                step_n      = 0;
  hap_pkg::result_t  awaited_q[$];
  hap_pkg::result_t  got;
  int                mismatches  = 0;
  int                queue_depth = 0;
  int                checked     = 0;

  assign errors  = mismatches;
  assign pending = queue_depth;
  assign records = checked;

  function automatic logic [4:0] hex_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic void emit(input logic [1:0] kind_code, input logic [2:0] slot,
                               input logic [31:0] value, input logic [3:0] count);
    step_out[step_n] = '{kind_code, slot, value, count, 1'b0};
    step_n++;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    logic [4:0] h;
    h = hex_of(c);
    if (h[4]) begin
      acc    = {acc[27:0], h[3:0]};
      digits = 1'b1;
    end
  endfunction

  function automatic void close_field();
    if (digits && slot_count < SLOTS) begin
      emit(hap_pkg::KIND_VALUE, slot_count[2:0], acc, 4'd0);
      slot_count++;
    end
    acc    = '0;
    digits = 1'b0;
  endfunction

  function automatic void restart();
    phase      = PH_FIRST;
    acc        = '0;
    digits     = 1'b0;
    slot_count = '0;
  endfunction

  task automatic consume_char(input logic [7:0] c);
    step_n = 0;
    case (phase)
      PH_FIRST, PH_SEEK: begin
        if (c == hap_pkg::CH_NUL) begin
          emit(hap_pkg::KIND_NO_PAREN, 3'd0, 32'd0, 4'd0);
          restart();
        end else if (phase == PH_FIRST) begin
          phase = PH_SEEK;
        end else if (c == hap_pkg::CH_OPEN) begin
          phase      = PH_LIST;
          acc        = '0;
          digits     = 1'b0;
          slot_count = '0;
        end
      end
      PH_LIST: begin
        if (c == hap_pkg::CH_NUL) begin
          close_field();
          emit(hap_pkg::KIND_DONE, 3'd0, 32'd0, slot_count);
          restart();
        end else if (c == hap_pkg::CH_COMMA) begin
          close_field();
          if (slot_count >= SLOTS) phase = PH_AFTER;
        end else if (c == hap_pkg::CH_CLOSE) begin
          close_field();
          phase = PH_AFTER;
        end else if (c == hap_pkg::CH_LF || c == hap_pkg::CH_CR) begin
          close_field();
          phase = PH_IDLE;
        end else if (c != hap_pkg::CH_SPACE) begin
          take_digit(c);
        end
      end
      PH_AFTER: begin
        if (c == hap_pkg::CH_NUL) begin
          emit(hap_pkg::KIND_DONE, 3'd0, 32'd0, slot_count);
          restart();
        end else if (c == hap_pkg::CH_EQUAL) begin
          acc    = '0;
          digits = 1'b0;
          phase  = PH_EQUAL;
        end else if (c != hap_pkg::CH_SPACE && c != hap_pkg::CH_CLOSE) begin
          phase = PH_IDLE;
        end
      end
      PH_EQUAL: begin
        if (c == hap_pkg::CH_NUL) begin
          close_field();
          emit(hap_pkg::KIND_DONE, 3'd0, 32'd0, slot_count);
          restart();
        end else if (c == hap_pkg::CH_COMMA || c == hap_pkg::CH_CLOSE ||
                     c == hap_pkg::CH_LF || c == hap_pkg::CH_CR) begin
          close_field();
          phase = PH_IDLE;
        end else if (c != hap_pkg::CH_SPACE) begin
          take_digit(c);
        end
      end
      default: begin
        if (c == hap_pkg::CH_NUL) begin
          emit(hap_pkg::KIND_DONE, 3'd0, 32'd0, slot_count);
          restart();
        end else begin
          phase = PH_IDLE;
        end
      end
    endcase
    for (int i = 0; i < step_n; i++) begin
      step_out[i].last_of_run = (i == step_n - 1);
      awaited_q.push_back(step_out[i]);
    end
  endtask

  task automatic report_mismatch(input string why, input hap_pkg::result_t want,
                                 input hap_pkg::result_t seen);
    if (mismatches < 40) begin
      $display({"[%0t] %s: want kind %0d slot %0d value %h count %0d last %0b, ",
                "got kind %0d slot %0d value %h count %0d last %0b"},
               $time, why, want.kind, want.slot_index, want.param_value, want.field_count,
               want.last_of_run, seen.kind, seen.slot_index, seen.param_value,
               seen.field_count, seen.last_of_run);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart();
      awaited_q.delete();
    end else begin
      if (s_tvalid && s_tready) consume_char(s_tdata);
      if (m_tvalid && m_tready) begin
        got.kind        = m_tuser;
        got.slot_index  = m_tdata[2:0];
        got.param_value = m_tdata[34:3];
        got.field_count = m_tdata[38:35];
        got.last_of_run = m_tlast;
        checked++;
        if (awaited_q.size() == 0) begin
          report_mismatch("record with none awaited", '0, got);
        end else begin
          if (got != awaited_q[0]) report_mismatch("record differs", awaited_q[0], got);
          void'(awaited_q.pop_front());
        end
      end
    end
    queue_depth = awaited_q.size();
  end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Hex argument list parser testbench
// Feeds directed command lines and then random ones, mostly well formed with
// random fields, spacing and junk, the rest noise or empty, under three idling mixes
// on both channels. A record check beside the parser predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_CHARS = 250;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int errors;
  int pending;
  int records;
  int src_idle_pct  = 14;
  int sink_idle_pct = 47;
  int chars_sent    = 0;
  int commands_sent = 0;
  int stall_cycles  = 0;

  hex_argument_list_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  hap_record_check record_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending),
    .records  (records)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  task automatic send_command(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(hap_pkg::CH_NUL);
    commands_sent++;
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(1, 255));
  endfunction

  // digits with spaces, junk and the odd arbitrary byte mixed in
  function automatic void add_field(ref logic [7:0] q[$]);
    int ndig;
    int r;
    ndig = ($urandom_range(3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
    for (int i = 0; i < ndig; i++) begin
      r = $urandom_range(99);
      if (r < 15) q.push_back(hap_pkg::CH_SPACE);
      else if (r < 20) q.push_back(pick("ghkxyzGHZ!#:;._~"));
      else if (r < 22) q.push_back(any_char());
      q.push_back(pick("0123456789abcdefABCDEF"));
    end
    if ($urandom_range(4) == 0) q.push_back(hap_pkg::CH_SPACE);
  endfunction

  task automatic send_random_command();
    logic [7:0] cmd[$];
    int shape;
    int fields;
    int r;
    shape = $urandom_range(99);
    if (shape < 3) begin
      // empty command: terminator only
    end else if (shape < 15) begin
      repeat ($urandom_range(1, 24)) begin
        if ($urandom_range(3) == 0) cmd.push_back(pick("(),= \n\r0aF"));
        else cmd.push_back(any_char());
      end
    end else begin
      cmd.push_back(any_char());
      repeat ($urandom_range(0, 4)) cmd.push_back(pick("ABCDxyz \n\r"));
      cmd.push_back(hap_pkg::CH_OPEN);
      fields = $urandom_range(0, 10);
      for (int f = 0; f < fields; f++) begin
        if (f > 0) cmd.push_back(hap_pkg::CH_COMMA);
        add_field(cmd);
      end
      r = $urandom_range(99);
      if (r < 80) begin
        cmd.push_back(hap_pkg::CH_CLOSE);
        if ($urandom_range(99) < 15) cmd.push_back(hap_pkg::CH_SPACE);
        if ($urandom_range(99) < 55) begin
          cmd.push_back(hap_pkg::CH_EQUAL);
          add_field(cmd);
        end
      end else if (r < 90) begin
        cmd.push_back(pick("\n\r"));
      end
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 4)) cmd.push_back(pick(",)=\n\rxy9 "));
      end
    end
    foreach (cmd[i]) send_char(cmd[i]);
    send_char(hap_pkg::CH_NUL);
    commands_sent++;
  endtask

  initial begin
    int target;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_char(hap_pkg::CH_NUL);
    commands_sent++;
    send_command("((F");
    send_command("C(,1\r2");
    send_command("C\n(fFfF0000a, x 9 )=");
    send_command("Q(1,2,3,4,5,6,7,8, ) =AbC");
    send_command("z(7)=12 ,9");
    send_command("z(7)k=5");
    send_command("z(1)=fedcba98");

    for (int p = 0; p < 3; p++) begin
      src_idle_pct  = (p == 0) ? 14 : (p == 1) ? 47 : 0;
      sink_idle_pct = (p == 0) ? 47 : (p == 1) ? 14 : 0;
      target = chars_sent + PHASE_CHARS;
      while (chars_sent < target) send_random_command();
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Parsed %0d command lines, %0d characters, under three idling mixes.",
             commands_sent, chars_sent);
    $display("Compared %0d result records; %0d mismatches.", records, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/hap_pkg.sv
rtl/hap_parser.sv
rtl/hap_out_fifo.sv
rtl/hex_argument_list_parser.sv
dv/hap_record_check.sv
dv/testbench.sv
